@@ hw/rtl/bounded_queue_with_drop_policy_unit_macros.svh @@
// Assertion macros for the bounded packet queue.
// Used by the top level; depends on nothing else.
`ifndef BOUNDED_QUEUE_WITH_DROP_POLICY_UNIT_MACROS_SVH
`define BOUNDED_QUEUE_WITH_DROP_POLICY_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BQD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bqd assertion failed");
// Next-cycle implication.
`define BQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bqd assertion failed");
`else
`define BQD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BQD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/bqd_pkg.sv @@
// Shared types and constants for the bounded packet queue.
// No dependencies.
package bqd_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ID_W   = 16;
    localparam int PRI_W  = 8;
    localparam int OCC_W  = 4;
    localparam int STAT_W = 3;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic POL_TAIL_DROP = 1'b0;
    localparam logic POL_PRIO_DROP = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_EVICTED  = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_DEQUEUED = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_DEQ   = 2'd1,
        OP_ENQ   = 2'd2,
        OP_EVICT = 2'd3
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] sel;   // write slot on enqueue, victim slot on evict
    } ctrl_t;

    // running minimum handed down the row
    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic [IDX_W-1:0] idx;
    } min_t;

endpackage

@@ hw/rtl/bqd_cell.sv @@
// One queue slot: holds an entry, shifts toward the head, feeds the min chain.
// Depends on bqd_pkg.
module bqd_cell (
    input  logic                        clk,
    input  logic [bqd_pkg::IDX_W-1:0]   idx,
    input  bqd_pkg::ctrl_t              ctrl,
    input  bqd_pkg::entry_t             in_data,
    input  bqd_pkg::entry_t             right_data,
    input  bqd_pkg::min_t               min_in,
    output bqd_pkg::entry_t             data,
    output bqd_pkg::min_t               min_out
);

    bqd_pkg::entry_t data_reg;
    bqd_pkg::entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            bqd_pkg::OP_DEQ:
            begin
                data_next = right_data;
            end
            bqd_pkg::OP_ENQ:
            begin
                if (idx == ctrl.sel)
                    data_next = in_data;
            end
            bqd_pkg::OP_EVICT:
            begin
                if (idx >= ctrl.sel)
                    data_next = right_data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // strict compare keeps the oldest slot on ties
    always_comb
    begin
        if (!min_in.valid || (data_reg.pri < min_in.pri))
        begin
            min_out.valid = 1'b1;
            min_out.id    = data_reg.id;
            min_out.pri   = data_reg.pri;
            min_out.idx   = idx;
        end
        else
        begin
            min_out = min_in;
        end
    end

    assign data = data_reg;

endmodule

@@ hw/rtl/bounded_queue_with_drop_policy_unit.sv @@
// Top level of the bounded packet queue with selectable overflow policy.
// Depends on bqd_pkg, bqd_cell and bounded_queue_with_drop_policy_unit_macros.svh.
//
// Usage:
//   Request channel: raise start with mode, packet_id and priority_req; the
//   request is taken at a clock edge where start is high and busy is low.
//   busy is always low here: one request may be issued every cycle.
//   Result channel: done pulses for one cycle, in the cycle after the request
//   was taken, with status, out_packet_id, out_priority and occupancy.
//   The receiver cannot stall; results must be captured when done is high.
//   Throughput 1 request per cycle.
//   Storage is a row of DEPTH cells, slot 0 the oldest. Dequeue shifts the
//   whole row toward the head; eviction shifts only the cells at and behind
//   the victim, and the last cell takes the new packet. The victim is found
//   by a running minimum passed down the row, which sets the cycle time.
//   drop_policy_we/drop_policy_wdata write the overflow policy (0 tail drop,
//   1 evict lowest priority); write it only while no request is in flight.
//   Reset clears the fill count, the policy and done; slot contents are
//   left as they are and are never read before being written.
`include "bounded_queue_with_drop_policy_unit_macros.svh"

module bounded_queue_with_drop_policy_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [bqd_pkg::ID_W-1:0]      packet_id,
    input  logic [bqd_pkg::PRI_W-1:0]     priority_req,
    input  logic                          drop_policy_we,
    input  logic                          drop_policy_wdata,
    output logic                          done,
    output logic [bqd_pkg::STAT_W-1:0]    status,
    output logic [bqd_pkg::ID_W-1:0]      out_packet_id,
    output logic [bqd_pkg::PRI_W-1:0]     out_priority,
    output logic [bqd_pkg::OCC_W-1:0]     occupancy
);

    localparam logic [bqd_pkg::CNT_W-1:0] FULL_CNT = bqd_pkg::CNT_W'(bqd_pkg::DEPTH);

    logic                          policy_reg;
    logic [bqd_pkg::CNT_W-1:0]     count_reg;
    logic [bqd_pkg::CNT_W-1:0]     count_next;
    logic                          done_reg;
    bqd_pkg::status_t              status_reg;
    bqd_pkg::status_t              status_next;
    logic [bqd_pkg::ID_W-1:0]      rid_reg;
    logic [bqd_pkg::ID_W-1:0]      rid_next;
    logic [bqd_pkg::PRI_W-1:0]     rpri_reg;
    logic [bqd_pkg::PRI_W-1:0]     rpri_next;
    logic [bqd_pkg::OCC_W-1:0]     occ_reg;

    bqd_pkg::ctrl_t                ctrl;
    bqd_pkg::entry_t               in_data;
    bqd_pkg::entry_t               cell_data [bqd_pkg::DEPTH];
    bqd_pkg::entry_t               right_data [bqd_pkg::DEPTH];
    bqd_pkg::min_t                 chain [bqd_pkg::DEPTH+1];

    logic                          accept;
    logic                          empty_res;
    logic                          overflow_res;

    assign busy    = 1'b0;   // the block never holds off a request
    assign accept  = start && !busy;
    assign in_data = '{id: packet_id, pri: priority_req};

    // head of the min chain: empty
    assign chain[0] = '{valid: 1'b0, id: '0, pri: '0, idx: '0};

    // cell row
    for (genvar i = 0; i < bqd_pkg::DEPTH; i++)
    begin : g_cell
        if (i == bqd_pkg::DEPTH - 1)
        begin : g_last
            assign right_data[i] = in_data;   // tail fills from the incoming packet
        end
        else
        begin : g_mid
            assign right_data[i] = cell_data[i+1];
        end

        bqd_cell u_cell (
            .clk        (clk),
            .idx        (bqd_pkg::IDX_W'(i)),
            .ctrl       (ctrl),
            .in_data    (in_data),
            .right_data (right_data[i]),
            .min_in     (chain[i]),
            .data       (cell_data[i]),
            .min_out    (chain[i+1])
        );
    end

    // request decode
    always_comb
    begin
        ctrl.op     = bqd_pkg::OP_NONE;
        ctrl.sel    = bqd_pkg::IDX_W'(count_reg);
        count_next  = count_reg;
        status_next = bqd_pkg::ST_ADDED;
        rid_next    = '0;
        rpri_next   = '0;
        if (mode == bqd_pkg::MODE_DEQ)
        begin
            if (count_reg == '0)
            begin
                status_next = bqd_pkg::ST_EMPTY;
            end
            else
            begin
                ctrl.op     = bqd_pkg::OP_DEQ;
                status_next = bqd_pkg::ST_DEQUEUED;
                rid_next    = cell_data[0].id;
                rpri_next   = cell_data[0].pri;
                count_next  = count_reg - 1'b1;
            end
        end
        else if (count_reg < FULL_CNT)
        begin
            ctrl.op     = bqd_pkg::OP_ENQ;
            status_next = bqd_pkg::ST_ADDED;
            count_next  = count_reg + 1'b1;
        end
        else if (policy_reg == bqd_pkg::POL_TAIL_DROP)
        begin
            status_next = bqd_pkg::ST_DROPPED;
            rid_next    = packet_id;
            rpri_next   = priority_req;
        end
        else
        begin
            // full: evict the oldest lowest-priority entry, append at tail
            ctrl.op     = bqd_pkg::OP_EVICT;
            ctrl.sel    = chain[bqd_pkg::DEPTH].idx;
            status_next = bqd_pkg::ST_EVICTED;
            rid_next    = chain[bqd_pkg::DEPTH].id;
            rpri_next   = chain[bqd_pkg::DEPTH].pri;
        end
        if (!accept)
        begin
            ctrl.op    = bqd_pkg::OP_NONE;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= bqd_pkg::POL_TAIL_DROP;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (drop_policy_we)
                policy_reg <= drop_policy_wdata;
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // result payload, qualified by done
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rid_reg    <= rid_next;
            rpri_reg   <= rpri_next;
            occ_reg    <= bqd_pkg::OCC_W'(count_next);
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign out_packet_id = rid_reg;
    assign out_priority  = rpri_reg;
    assign occupancy     = occ_reg;

    // result kinds checked against the fill count
    assign empty_res    = done && (status == bqd_pkg::ST_EMPTY);
    assign overflow_res = done && ((status == bqd_pkg::ST_EVICTED) ||
                                   (status == bqd_pkg::ST_DROPPED));

    `BQD_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `BQD_ASSERT_NEXT(a_done_follows, clk, rst_n, accept, done)
    `BQD_ASSERT_NEXT(a_idle_hold, clk, rst_n, !accept, $stable(count_reg) && !done)
    `BQD_ASSERT_IMPL(a_empty_zero, clk, rst_n, empty_res, count_reg == '0)
    `BQD_ASSERT_IMPL(a_overflow_full, clk, rst_n, overflow_res, count_reg == FULL_CNT)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for bounded_queue_with_drop_policy_unit.
// Depends on bqd_pkg and the RTL only; a shadow queue in this file predicts every result.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected response to one request, compared field by field.
    typedef struct {
        bqd_pkg::status_t          status;
        logic [bqd_pkg::ID_W-1:0]  id;
        logic [bqd_pkg::PRI_W-1:0] pri;
        logic [bqd_pkg::OCC_W-1:0] occ;
    } queue_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       mode;
    logic [bqd_pkg::ID_W-1:0]   packet_id;
    logic [bqd_pkg::PRI_W-1:0]  priority_req;
    logic                       drop_policy_we;
    logic                       drop_policy_wdata;
    logic                       done;
    logic [bqd_pkg::STAT_W-1:0] status;
    logic [bqd_pkg::ID_W-1:0]   out_packet_id;
    logic [bqd_pkg::PRI_W-1:0]  out_priority;
    logic [bqd_pkg::OCC_W-1:0]  occupancy;

    // Shadow copy of the queue contents (index 0 is the oldest) and of the policy.
    bqd_pkg::entry_t shadow_entries[$];
    logic            shadow_policy;
    // Responses still owed by the block, oldest first.
    queue_result_t   expected_results[$];
    int              mismatch_count = 0;
    // Requests left in the current sender burst.
    int              burst_left = 0;

    bounded_queue_with_drop_policy_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .packet_id        (packet_id),
        .priority_req     (priority_req),
        .drop_policy_we   (drop_policy_we),
        .drop_policy_wdata(drop_policy_wdata),
        .done             (done),
        .status           (status),
        .out_packet_id    (out_packet_id),
        .out_priority     (out_priority),
        .occupancy        (occupancy)
    );

    always #6 clk = ~clk;

    // Hard stop in case the block never answers or never leaves busy.
    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction: apply one accepted request to the shadow queue.
    // Dequeue takes the head; an enqueue into a full queue either drops
    // the incoming packet or evicts the oldest lowest-priority entry and
    // then appends the new one, whatever its own priority.
    // ------------------------------------------------------------------
    function automatic void predict_queue_op(input logic op_mode,
                                             input logic [bqd_pkg::ID_W-1:0] id,
                                             input logic [bqd_pkg::PRI_W-1:0] pri);
        queue_result_t   r;
        bqd_pkg::entry_t e;
        int              victim;
        r.id  = '0;
        r.pri = '0;
        if (op_mode == bqd_pkg::MODE_DEQ)
        begin
            if (shadow_entries.size() == 0)
            begin
                // empty queue: error status, contents untouched
                r.status = bqd_pkg::ST_EMPTY;
            end
            else
            begin
                e        = shadow_entries.pop_front();
                r.status = bqd_pkg::ST_DEQUEUED;
                r.id     = e.id;
                r.pri    = e.pri;
            end
        end
        else if (shadow_entries.size() < bqd_pkg::DEPTH)
        begin
            e.id     = id;
            e.pri    = pri;
            shadow_entries.push_back(e);
            r.status = bqd_pkg::ST_ADDED;
        end
        else if (shadow_policy == bqd_pkg::POL_TAIL_DROP)
        begin
            r.status = bqd_pkg::ST_DROPPED;
            r.id     = id;
            r.pri    = pri;
        end
        else
        begin
            // strict less-than keeps the oldest entry on a priority tie
            victim = 0;
            for (int i = 1; i < shadow_entries.size(); i++)
            begin
                if (shadow_entries[i].pri < shadow_entries[victim].pri)
                    victim = i;
            end
            r.status = bqd_pkg::ST_EVICTED;
            r.id     = shadow_entries[victim].id;
            r.pri    = shadow_entries[victim].pri;
            shadow_entries.delete(victim);
            e.id     = id;
            e.pri    = pri;
            shadow_entries.push_back(e);
        end
        r.occ = bqd_pkg::OCC_W'(shadow_entries.size());
        expected_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Result checking. done is a one-cycle strobe that cannot be held
    // off, so every edge with done high carries a result to compare.
    // Values are sampled at the edge, before the block updates them.
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [bqd_pkg::ID_W-1:0] want,
                               input logic [bqd_pkg::ID_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        queue_result_t r;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual status %0h id %0h",
                         $time, status, out_packet_id);
            end
            else
            begin
                r = expected_results.pop_front();
                check_field("status", bqd_pkg::ID_W'(r.status), bqd_pkg::ID_W'(status));
                check_field("out_packet_id", r.id, out_packet_id);
                check_field("out_priority", bqd_pkg::ID_W'(r.pri),
                            bqd_pkg::ID_W'(out_priority));
                check_field("occupancy", bqd_pkg::ID_W'(r.occ), bqd_pkg::ID_W'(occupancy));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side. Called at a rising edge; start stays high on return
    // so back-to-back requests go out on consecutive cycles.
    // ------------------------------------------------------------------
    task automatic issue_request(input logic op_mode, input logic [bqd_pkg::ID_W-1:0] id,
                                 input logic [bqd_pkg::PRI_W-1:0] pri);
        start        <= 1'b1;
        mode         <= op_mode;
        packet_id    <= id;
        priority_req <= pri;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_queue_op(op_mode, id, pri);
    endtask

    // Gap between bursts; the payload wiggles while start is low.
    task automatic idle_cycles(input int n);
        start        <= 1'b0;
        mode         <= 1'($urandom);
        packet_id    <= bqd_pkg::ID_W'($urandom);
        priority_req <= bqd_pkg::PRI_W'($urandom);
        repeat (n) @(posedge clk);
    endtask

    task automatic pace_sender();
        if (burst_left == 0)
        begin
            idle_cycles($urandom_range(1, 5));
            burst_left = $urandom_range(1, 16);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Stop sending until every outstanding request has been answered.
    task automatic wait_until_idle();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Policy register; only written with nothing in flight.
    task automatic set_drop_policy(input logic policy);
        drop_policy_we    <= 1'b1;
        drop_policy_wdata <= policy;
        @(posedge clk);
        drop_policy_we    <= 1'b0;
        shadow_policy = policy;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Dequeue straight after reset must report empty.
    task automatic test_empty_dequeue();
        issue_request(bqd_pkg::MODE_DEQ, 16'h5a5a, 8'ha5);
    endtask

    // Fill with field extremes, then overflow under the reset policy
    // (tail drop) so the incoming packets come back as dropped.
    task automatic test_tail_drop_full_queue();
        issue_request(bqd_pkg::MODE_ENQ, 16'hffff, 8'h00);   // lowest priority at the head
        issue_request(bqd_pkg::MODE_ENQ, 16'h0000, 8'hff);
        issue_request(bqd_pkg::MODE_ENQ, 16'h1234, 8'h40);
        issue_request(bqd_pkg::MODE_ENQ, 16'h5678, 8'h40);
        issue_request(bqd_pkg::MODE_ENQ, 16'h9abc, 8'h80);
        issue_request(bqd_pkg::MODE_ENQ, 16'h0001, 8'h20);   // tie pair at 0x20
        issue_request(bqd_pkg::MODE_ENQ, 16'h8000, 8'h20);
        issue_request(bqd_pkg::MODE_ENQ, 16'h7fff, 8'hfe);
        issue_request(bqd_pkg::MODE_ENQ, 16'hbeef, 8'hff);
        issue_request(bqd_pkg::MODE_ENQ, 16'h0000, 8'h00);
    endtask

    // Switch to priority discard with the queue full and walk the
    // victim through head, tail and a tie, appending new packets at the tail.
    task automatic test_lowest_priority_evict();
        wait_until_idle();
        set_drop_policy(bqd_pkg::POL_PRIO_DROP);
        issue_request(bqd_pkg::MODE_ENQ, 16'h1111, 8'h10);   // evicts the head
        issue_request(bqd_pkg::MODE_ENQ, 16'h2222, 8'h50);   // evicts the tail just added
        // tie at 0x20, oldest goes; new one lowest
        issue_request(bqd_pkg::MODE_ENQ, 16'h3333, 8'h05);
        issue_request(bqd_pkg::MODE_ENQ, 16'h4444, 8'hff);   // evicts the lowest, now at the tail
    endtask

    // Empty the queue in order, then one dequeue too many.
    task automatic test_drain_to_empty();
        repeat (bqd_pkg::DEPTH + 1)
            issue_request(bqd_pkg::MODE_DEQ, bqd_pkg::ID_W'($urandom),
                          bqd_pkg::PRI_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Random traffic in phases. Each phase sets the policy and an enqueue
    // bias: a high bias keeps the queue full and overflowing, a low one
    // keeps it near empty. Priorities often come from a tiny range so
    // that eviction ties are frequent.
    // ------------------------------------------------------------------
    task automatic test_random_traffic();
        int                        enq_pct[8] = '{55, 90, 75, 35, 85, 60, 95, 50};
        bit                        pacing;
        logic                      op_mode;
        logic [bqd_pkg::PRI_W-1:0] pri;
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_until_idle();
            set_drop_policy(phase % 2 == 0 ? bqd_pkg::POL_TAIL_DROP : bqd_pkg::POL_PRIO_DROP);
            pacing = (phase != 2 && phase != 5);   // two phases run without gaps
            for (int i = 0; i < 125; i++)
            begin
                op_mode = ($urandom_range(0, 99) < enq_pct[phase]) ? bqd_pkg::MODE_ENQ
                                                                   : bqd_pkg::MODE_DEQ;
                pri     = ($urandom_range(0, 3) == 0) ? bqd_pkg::PRI_W'($urandom_range(0, 3))
                                                      : bqd_pkg::PRI_W'($urandom);
                issue_request(op_mode, bqd_pkg::ID_W'($urandom), pri);
                if (pacing)
                    pace_sender();
                // full stop mid-phase until all results are back
                if (phase == 3 && i == 60)
                    wait_until_idle();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        start             <= 1'b0;
        mode              <= bqd_pkg::MODE_ENQ;
        packet_id         <= '0;
        priority_req      <= '0;
        drop_policy_we    <= 1'b0;
        drop_policy_wdata <= bqd_pkg::POL_TAIL_DROP;
        shadow_policy = bqd_pkg::POL_TAIL_DROP;   // reset value of the register
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_dequeue();
        test_tail_drop_full_queue();
        test_lowest_priority_evict();
        test_drain_to_empty();
        test_random_traffic();

        wait_until_idle();
        repeat (3) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
